FILE: sv/esp_pkg.sv
// Package for the event segment proximity test: codes, widths and shared types.
// Depends on nothing; every other file but esp_if imports it.
package esp_pkg;

    localparam int RADIUS_W = 43;
    localparam int HEIGHT_W = 19;
    localparam int DIST_W = 44;
    localparam int CFG_IDX_W = 2;
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
    localparam int EYE_HALF_HEIGHT = 24;

    localparam logic [RADIUS_W-1:0] POINT_RAD_RESET = 43'd1048576;
    localparam logic [RADIUS_W-1:0] LINE_RAD_RESET = 43'd1048576;
    localparam logic [HEIGHT_W-1:0] MAX_HEIGHT_RESET = 19'd45;

    localparam logic [CFG_IDX_W-1:0] CFG_POINT_RAD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_RAD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HEIGHT = 2'd2;

    typedef enum logic [1:0] {
        REG_BEHIND = 2'd0,
        REG_INTERIOR = 2'd1,
        REG_END = 2'd2,
        REG_POINT = 2'd3
    } esp_region_t;

    typedef struct packed {
        logic        line;
        logic        eye;
        esp_region_t region;
    } esp_ctrl_t;

endpackage

FILE: sv/esp_if.sv
// Request and response channel interfaces of the event segment proximity test.
// Depends on nothing; the top level and its front and back stages use them.
interface esp_req_if #(parameter int COORD_BITS = 20) ();
    logic                         valid;
    logic                         ready;
    logic                         op;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] start_z;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic signed [COORD_BITS-1:0] end_z;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
    logic                         eye_offset;
    logic [42:0]                  radius_sq;

    modport source (output valid, op, start_x, start_y, start_z, end_x, end_y, end_z,
                    point_x, point_y, point_z, eye_offset, radius_sq, input ready);
    modport sink (input valid, op, start_x, start_y, start_z, end_x, end_y, end_z,
                  point_x, point_y, point_z, eye_offset, radius_sq, output ready);
endinterface

interface esp_rsp_if #(parameter int COORD_BITS = 20) ();
    logic                         valid;
    logic                         ready;
    logic                         hit;
    logic [1:0]                   region;
    logic signed [COORD_BITS-1:0] closest_x;
    logic signed [COORD_BITS-1:0] closest_y;
    logic signed [COORD_BITS-1:0] closest_z;
    logic [43:0]                  dist_sq;

    modport source (output valid, hit, region, closest_x, closest_y, closest_z, dist_sq,
                    input ready);
    modport sink (input valid, hit, region, closest_x, closest_y, closest_z, dist_sq,
                  output ready);
endinterface

FILE: sv/event_segment_proximity_test_top.sv
// Top level of the event segment proximity test: configuration registers and the pipeline.
// Depends on esp_pkg, esp_if, esp_front, esp_div_step and esp_back.
//
//   channel  dir  handshake          carries
//   req      in   valid/ready        one listener test request
//   rsp      out  valid/ready        hit, region, closest point, squared distance
//   cfg      in   cfg_we only        register index and data
//
// One request enters per cycle unless the pipeline is halted; a result passes through
// four front stages, one divider step per quotient bit, four back stages.
// Reset clears only valid bits and sets the configuration registers to their reset values.
// The whole pipeline halts while a result waits unread; nothing is lost or repeated.
module event_segment_proximity_test_top
    import esp_pkg::*;
#(
    parameter int COORD_BITS = 20
) (
    input  logic                 clk,
    input  logic                 rst_n,
    esp_req_if.sink              req,
    esp_rsp_if.source            rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [RADIUS_W-1:0]  cfg_data
);
    localparam int C = COORD_BITS;
    localparam int W = C + 1;
    localparam int LW = 2 * C + 2;
    localparam int NW = LW + W;
    localparam int CW = $bits(esp_ctrl_t);
    localparam int PW = 9 * C + 3 + RADIUS_W + LW + CW;

    logic [RADIUS_W-1:0] point_rad_reg, line_rad_reg;
    logic [HEIGHT_W-1:0] max_height_reg;
    logic                adv;
    logic                back_valid;

    logic                f_valid;
    esp_ctrl_t           f_ctrl, b_ctrl;
    logic signed [C-1:0] f_s [3], f_e [3], f_p [3];
    logic signed [C-1:0] b_s [3], b_e [3], b_p [3];
    logic [2:0]          f_neg, b_neg;
    logic [RADIUS_W-1:0] f_rad, b_rad;
    logic [LW-1:0]       f_len, f_pdist, b_pdist;
    logic [NW-1:0]       f_nprod [3];

    logic          div_v [W+1];
    logic [LW-1:0] div_d [W+1];
    logic [LW-1:0] div_r [W+1][3];
    logic [W-1:0]  div_n [W+1][3];
    logic [W-1:0]  div_q [W+1][3];
    logic [PW-1:0] div_p [W+1];

    assign adv = !back_valid || rsp.ready;
    assign req.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_rad_reg <= POINT_RAD_RESET;
            line_rad_reg <= LINE_RAD_RESET;
            max_height_reg <= MAX_HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_POINT_RAD:  point_rad_reg <= cfg_data;
                CFG_LINE_RAD:   line_rad_reg <= cfg_data;
                CFG_MAX_HEIGHT: max_height_reg <= cfg_data[HEIGHT_W-1:0];
                default:        ;
            endcase
        end
    end

    esp_front #(.COORD_BITS(C)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .req       (req),
        .point_rad (point_rad_reg),
        .line_rad  (line_rad_reg),
        .valid_o   (f_valid),
        .ctrl_o    (f_ctrl),
        .s_o       (f_s),
        .e_o       (f_e),
        .p_o       (f_p),
        .ln_neg_o  (f_neg),
        .rad_o     (f_rad),
        .len_o     (f_len),
        .pdist_o   (f_pdist),
        .nprod_o   (f_nprod)
    );

    assign div_v[0] = f_valid;
    assign div_d[0] = f_len;
    assign div_p[0] = {f_s[0], f_s[1], f_s[2], f_e[0], f_e[1], f_e[2],
                       f_p[0], f_p[1], f_p[2], f_neg, f_rad, f_pdist, f_ctrl};

    for (genvar k = 0; k < 3; k++)
    begin : g_div_in
        assign div_r[0][k] = f_nprod[k][NW-1:W];
        assign div_n[0][k] = f_nprod[k][W-1:0];
        assign div_q[0][k] = '0;
    end

    for (genvar i = 0; i < W; i++)
    begin : g_div
        esp_div_step #(.LW(LW), .W(W), .PW(PW)) u_step (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .valid_i (div_v[i]),
            .d_i     (div_d[i]),
            .r_i     (div_r[i]),
            .n_i     (div_n[i]),
            .q_i     (div_q[i]),
            .pass_i  (div_p[i]),
            .valid_o (div_v[i+1]),
            .d_o     (div_d[i+1]),
            .r_o     (div_r[i+1]),
            .n_o     (div_n[i+1]),
            .q_o     (div_q[i+1]),
            .pass_o  (div_p[i+1])
        );
    end

    assign {b_s[0], b_s[1], b_s[2], b_e[0], b_e[1], b_e[2],
            b_p[0], b_p[1], b_p[2], b_neg, b_rad, b_pdist, b_ctrl} = div_p[W];

    esp_back #(.COORD_BITS(C)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .valid_i    (div_v[W]),
        .ctrl_i     (b_ctrl),
        .s_i        (b_s),
        .e_i        (b_e),
        .p_i        (b_p),
        .ln_neg_i   (b_neg),
        .q_i        (div_q[W]),
        .rad_i      (b_rad),
        .pdist_i    (b_pdist),
        .max_height (max_height_reg),
        .valid_o    (back_valid),
        .rsp        (rsp)
    );
endmodule

FILE: sv/esp_front.sv
// Front stages: differences, products, sums, classification and the dividend product.
// Depends on esp_pkg and esp_req_if.
module esp_front
    import esp_pkg::*;
#(
    parameter int COORD_BITS = 20
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           adv,
    esp_req_if.sink                        req,
    input  logic [RADIUS_W-1:0]            point_rad,
    input  logic [RADIUS_W-1:0]            line_rad,
    output logic                           valid_o,
    output esp_ctrl_t                      ctrl_o,
    output logic signed [COORD_BITS-1:0]   s_o [3],
    output logic signed [COORD_BITS-1:0]   e_o [3],
    output logic signed [COORD_BITS-1:0]   p_o [3],
    output logic [2:0]                     ln_neg_o,
    output logic [RADIUS_W-1:0]            rad_o,
    output logic [2*COORD_BITS+1:0]        len_o,
    output logic [2*COORD_BITS+1:0]        pdist_o,
    output logic [3*COORD_BITS+2:0]        nprod_o [3]
);
    localparam int C = COORD_BITS;
    localparam int W = C + 1;
    localparam int LW = 2 * C + 2;
    localparam int DTW = 2 * W + 2;
    localparam int NW = LW + W;

    logic signed [C-1:0] s_in [3];
    logic signed [C-1:0] e_in [3];
    logic signed [C-1:0] p_in [3];

    logic [3:0] v_reg;
    esp_ctrl_t  ctrl1_reg, ctrl2_reg, ctrl3_reg, ctrl4_reg;
    esp_ctrl_t  ctrl4_next;

    logic signed [C-1:0] s1_reg [3], s2_reg [3], s3_reg [3], s4_reg [3];
    logic signed [C-1:0] e1_reg [3], e2_reg [3], e3_reg [3], e4_reg [3];
    logic signed [C-1:0] p1_reg [3], p2_reg [3], p3_reg [3], p4_reg [3];
    logic [RADIUS_W-1:0] rad1_reg, rad2_reg, rad3_reg, rad4_reg, rad1_next;

    logic signed [W-1:0]   ln1_reg [3], ln1_next [3];
    logic signed [W-1:0]   ps1_reg [3], ps1_next [3];
    logic signed [2*W-1:0] lnsq2_reg [3], dp2_reg [3], pss2_reg [3];
    logic [W-1:0]          mag2_reg [3], mag3_reg [3], mag2_next [3];
    logic [2:0]            neg2_reg, neg3_reg, neg4_reg;
    logic [LW-1:0]         len3_reg, len4_reg, pdist3_reg, pdist4_reg;
    logic [LW-1:0]         len3_next, pdist3_next;
    logic signed [DTW-1:0] dot3_reg, dot3_next;
    logic [LW-1:0]         dot_lo;
    logic [NW-1:0]         nprod4_reg [3];

    assign s_in[0] = req.start_x;
    assign s_in[1] = req.start_y;
    assign s_in[2] = req.start_z;
    assign e_in[0] = req.end_x;
    assign e_in[1] = req.end_y;
    assign e_in[2] = req.end_z;
    assign p_in[0] = req.point_x;
    assign p_in[1] = req.point_y;
    assign p_in[2] = req.point_z;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            ln1_next[k] = W'(e_in[k]) - W'(s_in[k]);
            ps1_next[k] = W'(p_in[k]) - W'(s_in[k]);
            mag2_next[k] = ln1_reg[k][W-1] ? W'(-ln1_reg[k]) : W'(ln1_reg[k]);
        end
        if (req.radius_sq != '0)
        begin
            rad1_next = req.radius_sq;
        end
        else
        begin
            rad1_next = req.op ? line_rad : point_rad;
        end
        len3_next = LW'($unsigned(lnsq2_reg[0])) + LW'($unsigned(lnsq2_reg[1]))
                  + LW'($unsigned(lnsq2_reg[2]));
        pdist3_next = LW'($unsigned(pss2_reg[0])) + LW'($unsigned(pss2_reg[1]))
                    + LW'($unsigned(pss2_reg[2]));
        dot3_next = DTW'(dp2_reg[0]) + DTW'(dp2_reg[1]) + DTW'(dp2_reg[2]);
        dot_lo = dot3_reg[LW-1:0];
        ctrl4_next = ctrl3_reg;
        priority if (!ctrl3_reg.line)
        begin
            ctrl4_next.region = REG_POINT;
        end
        else if (dot3_reg[DTW-1])
        begin
            ctrl4_next.region = REG_BEHIND;
        end
        else if ($unsigned(dot3_reg) < DTW'(len3_reg))
        begin
            ctrl4_next.region = REG_INTERIOR;
        end
        else
        begin
            ctrl4_next.region = REG_END;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[2:0], req.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctrl1_reg <= '{line: req.op, eye: req.eye_offset, region: REG_POINT};
            ctrl2_reg <= ctrl1_reg;
            ctrl3_reg <= ctrl2_reg;
            ctrl4_reg <= ctrl4_next;
            rad1_reg <= rad1_next;
            rad2_reg <= rad1_reg;
            rad3_reg <= rad2_reg;
            rad4_reg <= rad3_reg;
            neg2_reg <= {ln1_reg[2][W-1], ln1_reg[1][W-1], ln1_reg[0][W-1]};
            neg3_reg <= neg2_reg;
            neg4_reg <= neg3_reg;
            len3_reg <= len3_next;
            len4_reg <= len3_reg;
            pdist3_reg <= pdist3_next;
            pdist4_reg <= pdist3_reg;
            dot3_reg <= dot3_next;
            for (int k = 0; k < 3; k++)
            begin
                s1_reg[k] <= s_in[k];
                s2_reg[k] <= s1_reg[k];
                s3_reg[k] <= s2_reg[k];
                s4_reg[k] <= s3_reg[k];
                e1_reg[k] <= e_in[k];
                e2_reg[k] <= e1_reg[k];
                e3_reg[k] <= e2_reg[k];
                e4_reg[k] <= e3_reg[k];
                p1_reg[k] <= p_in[k];
                p2_reg[k] <= p1_reg[k];
                p3_reg[k] <= p2_reg[k];
                p4_reg[k] <= p3_reg[k];
                ln1_reg[k] <= ln1_next[k];
                ps1_reg[k] <= ps1_next[k];
                lnsq2_reg[k] <= ln1_reg[k] * ln1_reg[k];
                dp2_reg[k] <= ps1_reg[k] * ln1_reg[k];
                pss2_reg[k] <= ps1_reg[k] * ps1_reg[k];
                mag2_reg[k] <= mag2_next[k];
                mag3_reg[k] <= mag2_reg[k];
                nprod4_reg[k] <= NW'(dot_lo) * NW'(mag3_reg[k]);
            end
        end
    end

    assign valid_o = v_reg[3];
    assign ctrl_o = ctrl4_reg;
    assign s_o = s4_reg;
    assign e_o = e4_reg;
    assign p_o = p4_reg;
    assign ln_neg_o = neg4_reg;
    assign rad_o = rad4_reg;
    assign len_o = len4_reg;
    assign pdist_o = pdist4_reg;
    assign nprod_o = nprod4_reg;
endmodule

FILE: sv/esp_div_step.sv
// One registered restoring-division step for three lanes sharing one divisor.
// Depends on esp_pkg only through the common import convention.
module esp_div_step
    import esp_pkg::*;
#(
    parameter int LW = 42,
    parameter int W = 21,
    parameter int PW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          valid_i,
    input  logic [LW-1:0] d_i,
    input  logic [LW-1:0] r_i [3],
    input  logic [W-1:0]  n_i [3],
    input  logic [W-1:0]  q_i [3],
    input  logic [PW-1:0] pass_i,
    output logic          valid_o,
    output logic [LW-1:0] d_o,
    output logic [LW-1:0] r_o [3],
    output logic [W-1:0]  n_o [3],
    output logic [W-1:0]  q_o [3],
    output logic [PW-1:0] pass_o
);
    logic          valid_reg;
    logic [LW-1:0] d_reg;
    logic [LW-1:0] r_reg [3], r_next [3];
    logic [W-1:0]  n_reg [3];
    logic [W-1:0]  q_reg [3], q_next [3];
    logic [PW-1:0] pass_reg;
    logic [LW:0]   rs [3];
    logic [LW:0]   rd [3];
    logic          ge [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            rs[k] = {r_i[k], n_i[k][W-1]};
            ge[k] = rs[k] >= {1'b0, d_i};
            rd[k] = rs[k] - {1'b0, d_i};
            r_next[k] = ge[k] ? rd[k][LW-1:0] : rs[k][LW-1:0];
            q_next[k] = {q_i[k][W-2:0], ge[k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg <= d_i;
            pass_reg <= pass_i;
            for (int k = 0; k < 3; k++)
            begin
                r_reg[k] <= r_next[k];
                q_reg[k] <= q_next[k];
                n_reg[k] <= {n_i[k][W-2:0], 1'b0};
            end
        end
    end

    assign valid_o = valid_reg;
    assign d_o = d_reg;
    assign r_o = r_reg;
    assign n_o = n_reg;
    assign q_o = q_reg;
    assign pass_o = pass_reg;
endmodule

FILE: sv/esp_back.sv
// Back stages: closest point, distances, hit decision and the response register.
// Depends on esp_pkg and esp_rsp_if.
module esp_back
    import esp_pkg::*;
#(
    parameter int COORD_BITS = 20
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  logic                         valid_i,
    input  esp_ctrl_t                    ctrl_i,
    input  logic signed [COORD_BITS-1:0] s_i [3],
    input  logic signed [COORD_BITS-1:0] e_i [3],
    input  logic signed [COORD_BITS-1:0] p_i [3],
    input  logic [2:0]                   ln_neg_i,
    input  logic [COORD_BITS:0]          q_i [3],
    input  logic [RADIUS_W-1:0]          rad_i,
    input  logic [2*COORD_BITS+1:0]      pdist_i,
    input  logic [HEIGHT_W-1:0]          max_height,
    output logic                         valid_o,
    esp_rsp_if.source                    rsp
);
    localparam int C = COORD_BITS;
    localparam int W = C + 1;
    localparam int LW = 2 * C + 2;
    localparam int DW = (LW > DIST_W) ? LW : DIST_W;
    localparam int HW = (W > HEIGHT_W) ? W : HEIGHT_W;

    logic [3:0]          v_reg;
    esp_ctrl_t           ctrl1_reg, ctrl2_reg, ctrl3_reg;
    logic [RADIUS_W-1:0] rad1_reg, rad2_reg, rad3_reg;
    logic [LW-1:0]       pd1_reg, pd2_reg, pd3_reg;
    logic signed [C-1:0] c1_reg [3], c2_reg [3], c3_reg [3];
    logic signed [C-1:0] c1_next [3];
    logic signed [W-1:0] cw [3];
    logic signed [C-1:0] p1_reg [3];
    logic signed [W-1:0] dx2_reg, dy2_reg;
    logic signed [C+1:0] dz_next;
    logic [HW-1:0]       adz2_reg, adz3_reg, adz2_next;
    logic signed [2*W-1:0] sqx3_reg, sqy3_reg;
    logic [DW-1:0]       dist_sum;
    logic                hit_next;

    logic                hit_reg;
    logic [1:0]          region_reg;
    logic signed [C-1:0] cx_reg, cy_reg, cz_reg;
    logic [DIST_W-1:0]   dist_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            cw[k] = ln_neg_i[k] ? (W'(s_i[k]) - $signed(q_i[k]))
                                : (W'(s_i[k]) + $signed(q_i[k]));
            c1_next[k] = (ctrl_i.region == REG_INTERIOR) ? cw[k][C-1:0]
                       : (ctrl_i.region == REG_END) ? e_i[k] : s_i[k];
        end
        dz_next = (C+2)'(p1_reg[2]) - (C+2)'(c1_reg[2])
                + (ctrl1_reg.eye ? (C+2)'(EYE_HALF_HEIGHT) : '0);
        adz2_next = dz_next[C+1] ? HW'(-dz_next) : HW'(dz_next);
        hit_next = 1'b0;
        dist_sum = '0;
        unique case (ctrl3_reg.region)
            REG_POINT:
            begin
                dist_sum = DW'(pd3_reg);
                hit_next = dist_sum <= DW'(rad3_reg);
            end
            REG_BEHIND:
            begin
                dist_sum = '0;
                hit_next = 1'b0;
            end
            REG_INTERIOR, REG_END:
            begin
                dist_sum = DW'($unsigned(sqx3_reg)) + DW'($unsigned(sqy3_reg));
                hit_next = (dist_sum <= DW'(rad3_reg)) && (adz3_reg < HW'(max_height));
            end
            default:
            begin
                dist_sum = '0;
                hit_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[2:0], valid_i};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctrl1_reg <= ctrl_i;
            ctrl2_reg <= ctrl1_reg;
            ctrl3_reg <= ctrl2_reg;
            rad1_reg <= rad_i;
            rad2_reg <= rad1_reg;
            rad3_reg <= rad2_reg;
            pd1_reg <= pdist_i;
            pd2_reg <= pd1_reg;
            pd3_reg <= pd2_reg;
            for (int k = 0; k < 3; k++)
            begin
                c1_reg[k] <= c1_next[k];
                c2_reg[k] <= c1_reg[k];
                c3_reg[k] <= c2_reg[k];
                p1_reg[k] <= p_i[k];
            end
            dx2_reg <= W'(p1_reg[0]) - W'(c1_reg[0]);
            dy2_reg <= W'(p1_reg[1]) - W'(c1_reg[1]);
            adz2_reg <= adz2_next;
            adz3_reg <= adz2_reg;
            sqx3_reg <= dx2_reg * dx2_reg;
            sqy3_reg <= dy2_reg * dy2_reg;
            hit_reg <= hit_next;
            region_reg <= ctrl3_reg.region;
            if (ctrl3_reg.region == REG_BEHIND)
            begin
                cx_reg <= '0;
                cy_reg <= '0;
                cz_reg <= '0;
            end
            else
            begin
                cx_reg <= c3_reg[0];
                cy_reg <= c3_reg[1];
                cz_reg <= c3_reg[2];
            end
            dist_reg <= (dist_sum > DW'(DIST_MAX)) ? DIST_MAX : dist_sum[DIST_W-1:0];
        end
    end

    assign valid_o = v_reg[3];
    assign rsp.valid = v_reg[3];
    assign rsp.hit = hit_reg;
    assign rsp.region = region_reg;
    assign rsp.closest_x = cx_reg;
    assign rsp.closest_y = cy_reg;
    assign rsp.closest_z = cz_reg;
    assign rsp.dist_sq = dist_reg;
endmodule

FILE: tb/tb_event_segment_proximity_test_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for event_segment_proximity_test_top: directed and random listener tests.
// Depends on esp_pkg, esp_if and the block; checks use an in-bench predictor or typed results.
module tb_event_segment_proximity_test_top;
    import esp_pkg::*;

    localparam int CB = 20;
    localparam int LATENCY = CB + 9;
    localparam int CYCLE_LIMIT = 600000;
    localparam logic [RADIUS_W-1:0] RADIUS_ALL = {RADIUS_W{1'b1}};
    localparam logic [HEIGHT_W-1:0] HEIGHT_ALL = {HEIGHT_W{1'b1}};
    localparam logic [CB-1:0] C_MIN = {1'b1, {(CB-1){1'b0}}};
    localparam logic [CB-1:0] C_MAX = {1'b0, {(CB-1){1'b1}}};

    typedef struct {
        logic                 op;
        logic signed [CB-1:0] sx, sy, sz, ex, ey, ez, px, py, pz;
        logic                 eye;
        logic [RADIUS_W-1:0]  rad;
    } listener_req_t;

    typedef struct {
        logic                 hit;
        esp_region_t          region;
        logic signed [CB-1:0] cx, cy, cz;
        logic [DIST_W-1:0]    dist_sq;
    } proximity_t;

    typedef struct {
        listener_req_t rq;
        bit            typed;
        proximity_t    res;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [RADIUS_W-1:0] cfg_data;

    esp_req_if #(.COORD_BITS(CB)) req_ch ();
    esp_rsp_if #(.COORD_BITS(CB)) rsp_ch ();

    event_segment_proximity_test_top #(.COORD_BITS(CB)) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch.sink),
        .rsp     (rsp_ch.source),
        .cfg_we  (cfg_we),
        .cfg_idx (cfg_idx),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    logic [RADIUS_W-1:0] point_rad_reg;
    logic [RADIUS_W-1:0] line_rad_reg;
    logic [HEIGHT_W-1:0] height_reg;
    proximity_t pending_q[$];
    stim_row_t directed_rows[$];
    int errors = 0;
    int results_seen = 0;
    int hits_seen = 0;
    int sent = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_go = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int cycles = 0;

    function automatic longint signed absl(longint signed v);
        return v < 0 ? -v : v;
    endfunction

    function automatic proximity_t predict_proximity(listener_req_t r);
        proximity_t o;
        longint signed s[3], e[3], p[3], c[3], ln[3];
        longint signed dot, dz;
        longint unsigned len_sq, dsq, rad;
        logic [127:0] prod;
        longint signed q;
        s = '{longint'(r.sx), longint'(r.sy), longint'(r.sz)};
        e = '{longint'(r.ex), longint'(r.ey), longint'(r.ez)};
        p = '{longint'(r.px), longint'(r.py), longint'(r.pz)};
        o = '{1'b0, REG_BEHIND, '0, '0, '0, '0};
        if (!r.op) begin
            rad = (r.rad == 0) ? point_rad_reg : r.rad;
            dsq = 0;
            for (int k = 0; k < 3; k++)
                dsq += (p[k] - s[k]) * (p[k] - s[k]);
            o.hit = dsq <= rad;
            o.region = REG_POINT;
            o.cx = r.sx;
            o.cy = r.sy;
            o.cz = r.sz;
            o.dist_sq = (dsq > DIST_MAX) ? DIST_MAX : dsq[DIST_W-1:0];
            return o;
        end
        rad = (r.rad == 0) ? line_rad_reg : r.rad;
        len_sq = 0;
        dot = 0;
        for (int k = 0; k < 3; k++) begin
            ln[k] = e[k] - s[k];
            len_sq += ln[k] * ln[k];
            dot += (p[k] - s[k]) * ln[k];
        end
        if (dot < 0)
            return o;
        if (longint'(dot) < longint'(len_sq)) begin
            o.region = REG_INTERIOR;
            for (int k = 0; k < 3; k++) begin
                prod = 128'(dot) * 128'(absl(ln[k]));
                q = longint'(prod / 128'(len_sq));
                c[k] = s[k] + (ln[k] < 0 ? -q : q);
            end
        end
        else begin
            o.region = REG_END;
            c = e;
        end
        dsq = (p[0] - c[0]) * (p[0] - c[0]) + (p[1] - c[1]) * (p[1] - c[1]);
        dz = p[2] - c[2] + (r.eye ? EYE_HALF_HEIGHT : 0);
        o.hit = (dsq <= rad) && (absl(dz) < longint'(height_reg));
        o.cx = c[0][CB-1:0];
        o.cy = c[1][CB-1:0];
        o.cz = c[2][CB-1:0];
        o.dist_sq = (dsq > DIST_MAX) ? DIST_MAX : dsq[DIST_W-1:0];
        return o;
    endfunction

    function automatic logic [CB-1:0] near_coord(logic [CB-1:0] base, int spread);
        return base + CB'($urandom_range(2 * spread) - spread);
    endfunction

    function automatic listener_req_t random_request();
        listener_req_t r;
        int spread;
        r.op = 1'($urandom_range(1));
        r.eye = 1'($urandom_range(1));
        r.sx = CB'($urandom);
        r.sy = CB'($urandom);
        r.sz = CB'($urandom);
        if ($urandom_range(2) == 0) begin
            r.ex = CB'($urandom);
            r.ey = CB'($urandom);
            r.ez = CB'($urandom);
            r.px = CB'($urandom);
            r.py = CB'($urandom);
            r.pz = CB'($urandom);
        end
        else begin
            spread = ($urandom_range(3) == 0) ? 100000 : 2000;
            r.ex = near_coord(r.sx, spread);
            r.ey = near_coord(r.sy, spread);
            r.ez = ($urandom_range(1) == 0) ? r.sz : near_coord(r.sz, 40);
            r.px = near_coord(r.sx, spread);
            r.py = near_coord(r.sy, spread);
            r.pz = near_coord(r.sz, 60);
            if ($urandom_range(7) == 0)
                {r.ex, r.ey, r.ez} = {r.sx, r.sy, r.sz};
        end
        case ($urandom_range(3))
            0: r.rad = '0;
            1: r.rad = RADIUS_W'($urandom_range(4000000));
            2: r.rad = RADIUS_W'({$urandom, $urandom});
            default: r.rad = 43'(longint'($urandom_range(1000000)) * 30);
        endcase
        return r;
    endfunction

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [RADIUS_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_POINT_RAD: point_rad_reg = data;
            CFG_LINE_RAD: line_rad_reg = data;
            CFG_MAX_HEIGHT: height_reg = data[HEIGHT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic drain_results();
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic send_request(listener_req_t r, bit typed, proximity_t res);
        if ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        req_ch.valid <= 1'b1;
        req_ch.op <= r.op;
        req_ch.start_x <= r.sx;
        req_ch.start_y <= r.sy;
        req_ch.start_z <= r.sz;
        req_ch.end_x <= r.ex;
        req_ch.end_y <= r.ey;
        req_ch.end_z <= r.ez;
        req_ch.point_x <= r.px;
        req_ch.point_y <= r.py;
        req_ch.point_z <= r.pz;
        req_ch.eye_offset <= r.eye;
        req_ch.radius_sq <= r.rad;
        do
            @(posedge clk);
        while (!req_ch.ready);
        pending_q.push_back(typed ? res : predict_proximity(r));
        sent++;
    endtask

    task automatic add_row(logic op, logic [CB-1:0] sx, sy, sz, ex, ey, ez, px, py, pz,
                           logic eye, logic [RADIUS_W-1:0] rad, bit typed,
                           proximity_t res = '{1'b0, REG_BEHIND, '0, '0, '0, '0});
        stim_row_t row;
        row.rq = '{op, sx, sy, sz, ex, ey, ez, px, py, pz, eye, rad};
        row.typed = typed;
        row.res = res;
        directed_rows.push_back(row);
    endtask

    task automatic random_phase(int count);
        proximity_t none;
        none = '{1'b0, REG_BEHIND, '0, '0, '0, '0};
        repeat (count)
            send_request(random_request(), 1'b0, none);
        req_ch.valid <= 1'b0;
        drain_results();
    endtask

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("event_segment_proximity_test_top test failed");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (hold_go != hold_seen) begin
            hold_seen = hold_go;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end
        else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk) begin
        proximity_t exp_res;
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (pending_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result hit=%0b region=%0d", $time, rsp_ch.hit,
                         rsp_ch.region);
            end
            else begin
                exp_res = pending_q.pop_front();
                hits_seen += rsp_ch.hit;
                if (rsp_ch.hit !== exp_res.hit || rsp_ch.region !== exp_res.region
                    || rsp_ch.closest_x !== exp_res.cx || rsp_ch.closest_y !== exp_res.cy
                    || rsp_ch.closest_z !== exp_res.cz || rsp_ch.dist_sq !== exp_res.dist_sq)
                begin
                    errors++;
                    $display("%0t: expected hit=%0b region=%0d closest=(%0d,%0d,%0d) dist=%0d",
                             $time, exp_res.hit, exp_res.region, exp_res.cx, exp_res.cy,
                             exp_res.cz, exp_res.dist_sq);
                    $display("%0t: actual   hit=%0b region=%0d closest=(%0d,%0d,%0d) dist=%0d",
                             $time, rsp_ch.hit, rsp_ch.region, rsp_ch.closest_x,
                             rsp_ch.closest_y, rsp_ch.closest_z, rsp_ch.dist_sq);
                end
            end
        end
    end

    initial begin
        proximity_t none;
        none = '{1'b0, REG_BEHIND, '0, '0, '0, '0};
        req_ch.valid <= 1'b0;
        req_ch.op <= 1'b0;
        {req_ch.start_x, req_ch.start_y, req_ch.start_z} <= '0;
        {req_ch.end_x, req_ch.end_y, req_ch.end_z} <= '0;
        {req_ch.point_x, req_ch.point_y, req_ch.point_z} <= '0;
        req_ch.eye_offset <= 1'b0;
        req_ch.radius_sq <= '0;
        cfg_we <= 1'b0;
        cfg_idx <= '0;
        cfg_data <= '0;
        point_rad_reg = POINT_RAD_RESET;
        line_rad_reg = LINE_RAD_RESET;
        height_reg = MAX_HEIGHT_RESET;

        add_row(1'b0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0, 0, 1,
                '{1'b1, REG_POINT, 20'sd0, 20'sd0, 20'sd0, 44'd0});
        add_row(1'b0, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
                1'b1, RADIUS_ALL, 1,
                '{1'b1, REG_POINT, -20'sd524288, -20'sd524288, -20'sd524288,
                  44'd3298528591875});
        add_row(1'b0, C_MAX, C_MIN, 0, 0, 0, 0, C_MIN, C_MAX, 0, 1'b0, 0, 0);
        add_row(1'b0, 10, 20, 30, 0, 0, 0, 1034, 20, 30, 1'b0, 0, 1,
                '{1'b1, REG_POINT, 20'sd10, 20'sd20, 20'sd30, 44'd1048576});
        add_row(1'b0, 10, 20, 30, 0, 0, 0, 1035, 20, 30, 1'b0, 0, 1,
                '{1'b0, REG_POINT, 20'sd10, 20'sd20, 20'sd30, 44'd1050625});
        add_row(1'b1, 0, 0, 0, 100, 0, 0, -10, 0, 0, 1'b0, 0, 1, none);
        add_row(1'b1, 5, 5, 5, 5, 5, 5, 5, 5, 5, 1'b0, 0, 1,
                '{1'b1, REG_END, 20'sd5, 20'sd5, 20'sd5, 44'd0});
        add_row(1'b1, 5, 5, 5, 5, 5, 5, 5, 5, 5, 1'b1, 0, 1,
                '{1'b1, REG_END, 20'sd5, 20'sd5, 20'sd5, 44'd0});
        add_row(1'b1, 5, 5, 5, 5, 5, 5, 5, 5, 30, 1'b1, 0, 1,
                '{1'b0, REG_END, 20'sd5, 20'sd5, 20'sd5, 44'd0});
        add_row(1'b1, 0, 0, 0, 100, 0, 0, 50, 30, 0, 1'b0, 0, 1,
                '{1'b1, REG_INTERIOR, 20'sd50, 20'sd0, 20'sd0, 44'd900});
        add_row(1'b1, 0, 0, 0, 100, 0, 0, 150, 0, 0, 1'b0, 0, 1,
                '{1'b1, REG_END, 20'sd100, 20'sd0, 20'sd0, 44'd2500});
        add_row(1'b1, 0, 0, 0, 3, 7, -2, 1, 1, 1, 1'b1, 5000, 0);
        add_row(1'b1, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 0, 0, 0, 1'b1, RADIUS_ALL, 0);
        add_row(1'b1, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, 7, -3, 11, 1'b0, 1, 0);
        add_row(1'b1, C_MAX, C_MIN, 0, C_MIN, C_MAX, 0, C_MAX, C_MAX, C_MIN, 1'b1, 0, 0);
        add_row(1'b1, 0, 0, 0, -9, 4, 13, -5, 2, 6, 1'b0, 0, 0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].res);
        req_ch.valid <= 1'b0;
        drain_results();
        random_phase(120);

        write_register(CFG_POINT_RAD, '0);
        write_register(CFG_LINE_RAD, '0);
        write_register(CFG_MAX_HEIGHT, '0);
        send_idle_pct = 88;
        random_phase(110);

        write_register(CFG_POINT_RAD, RADIUS_ALL);
        write_register(CFG_LINE_RAD, RADIUS_ALL);
        write_register(CFG_MAX_HEIGHT, {{(RADIUS_W-HEIGHT_W){1'b0}}, HEIGHT_ALL});
        send_idle_pct = 0;
        recv_stall_pct = 88;
        random_phase(110);

        write_register(CFG_POINT_RAD, RADIUS_W'({$urandom, $urandom}));
        write_register(CFG_LINE_RAD, 43'($urandom_range(3000000)));
        write_register(CFG_MAX_HEIGHT, 43'($urandom_range(200)));
        send_idle_pct = 14;
        recv_stall_pct = 14;
        random_phase(110);

        write_register(CFG_MAX_HEIGHT, 43'd60);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_go++;
        random_phase(140);

        $display("Sent %0d listener requests over five register settings and idle patterns;",
                 sent);
        $display("%0d results checked, %0d of them hits.", results_seen, hits_seen);
        if (errors == 0 && pending_q.size() == 0)
            $display("event_segment_proximity_test_top test passed");
        else
            $display("event_segment_proximity_test_top test failed");
        $finish;
    end

endmodule
